### src/greedy_box_suppression_top_assert.svh
// assertion macros for the greedy box suppression block
// used by the port checker, needs clk and rst_n in scope
`ifndef GREEDY_BOX_SUPPRESSION_TOP_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define GBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbs check failed");

// next-cycle implication, masked during reset
`define GBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbs check failed");

// next-cycle implication that also holds across reset
`define GBS_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gbs check failed");

`endif

### src/gbs_pkg.sv
// shared constants and types for greedy box suppression
// no dependencies
`default_nettype none
package gbs_pkg;
  localparam int MAX_KEPT = 64;
  localparam int KEPT_AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KEPT_CW  = $clog2(MAX_KEPT + 1);
  localparam int Q_DEPTH  = 2;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 9;

  localparam logic [CFG_IW-1:0] CFG_THR = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_AGN = 1'd1;
  localparam logic [8:0] THR_RESET = 9'd115;

  // item as it travels from front to back
  typedef struct packed {
    logic               set_start;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [7:0]         label;
    logic [29:0]        area;
    logic [15:0]        index;
  } box_t;

  // stored kept box
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [29:0]        area;
    logic [7:0]         label;
  } kept_t;

  typedef struct packed {
    logic [8:0] thr;
    logic       agnostic;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_DRAIN
  } back_state_t;
endpackage
`default_nettype wire

### src/gbs_if.sv
// valid/ready channel interfaces for input and result items
// no dependencies
`default_nettype none
interface gbs_in_if;
  logic               valid;
  logic               ready;
  logic               set_start;
  logic signed [15:0] box_left;
  logic signed [15:0] box_top;
  logic [14:0]        box_width;
  logic [14:0]        box_height;
  logic [7:0]         class_label;
  modport source (output valid, set_start, box_left, box_top, box_width, box_height,
                  class_label, input ready);
  modport sink (input valid, set_start, box_left, box_top, box_width, box_height,
                class_label, output ready);
endinterface

interface gbs_out_if;
  logic        valid;
  logic        ready;
  logic        keep;
  logic [15:0] box_index;
  logic        table_full;
  modport source (output valid, keep, box_index, table_full, input ready);
  modport sink (input valid, keep, box_index, table_full, output ready);
endinterface
`default_nettype wire

### src/gbs_queue.sv
// short item queue between front and back
// depends on gbs_pkg
`default_nettype none
module gbs_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire gbs_pkg::box_t push_data,
  input  wire logic          pop,
  output gbs_pkg::box_t      pop_data,
  output gbs_pkg::qstat_t    stat
);
  gbs_pkg::box_t                  mem_r [gbs_pkg::Q_DEPTH];
  logic [gbs_pkg::Q_AW-1:0]       wp_r, rp_r;
  logic [gbs_pkg::Q_CW-1:0]       cnt_r;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == gbs_pkg::Q_CW'(gbs_pkg::Q_DEPTH));
  assign pop_data   = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == gbs_pkg::Q_AW'(gbs_pkg::Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == gbs_pkg::Q_AW'(gbs_pkg::Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule
`default_nettype wire

### src/gbs_front.sv
// front end: accepts items, assigns set index, computes box area
// depends on gbs_pkg and gbs_in_if
`default_nettype none
module gbs_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  gbs_in_if.sink               in_ch,
  input  wire gbs_pkg::qstat_t qstat,
  output logic                 push,
  output gbs_pkg::box_t        push_data
);
  logic [15:0] pos_r, pos_nxt, idx;

  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && in_ch.ready;

  // index within the set, saturating
  always_comb begin
    idx     = in_ch.set_start ? 16'd0 : pos_r;
    pos_nxt = (idx != 16'hFFFF) ? idx + 16'd1 : idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)    pos_r <= '0;
    else if (push) pos_r <= pos_nxt;
  end

  // classified item for the queue
  always_comb begin
    push_data.set_start = in_ch.set_start;
    push_data.left      = in_ch.box_left;
    push_data.top       = in_ch.box_top;
    push_data.width     = in_ch.box_width;
    push_data.height    = in_ch.box_height;
    push_data.label     = in_ch.class_label;
    push_data.area      = 30'(in_ch.box_width) * 30'(in_ch.box_height);
    push_data.index     = idx;
  end
endmodule
`default_nettype wire

### src/gbs_back.sv
// back end: walks the kept table through an overlap pipeline, stores survivors
// depends on gbs_pkg and gbs_out_if
`default_nettype none
module gbs_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gbs_pkg::cfg_t   cfg,
  input  wire gbs_pkg::qstat_t qstat,
  input  wire gbs_pkg::box_t   q_data,
  output logic                 q_pop,
  gbs_out_if.source            out_ch
);
  localparam int AW = gbs_pkg::KEPT_AW;
  localparam int CW = gbs_pkg::KEPT_CW;

  gbs_pkg::back_state_t state_r, state_nxt;
  gbs_pkg::box_t        cur_r;
  gbs_pkg::kept_t       mem_r [gbs_pkg::MAX_KEPT];
  gbs_pkg::kept_t       rdata_r;
  logic [CW-1:0]        cnt_r;
  logic [AW-1:0]        rd_r;
  logic                 supp_r;
  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [14:0]          dx2_r, dy2_r;
  logic [29:0]          ka2_r, ka3_r, in3_r, in4_r, in5_r;
  logic                 m2_r, m3_r, m4_r, m5_r;
  logic [30:0]          un4_r;
  logic [39:0]          pr5_r;
  logic                 out_valid_r, out_keep_r, out_full_r;
  logic [15:0]          out_index_r;

  logic                 issue, fin, pipe_empty, out_free, last_rd, keep_now, full_now;
  logic [CW-1:0]        eff_cnt;
  logic signed [16:0]   a0, a1, b0, b1, c0, c1, d0, d1, xlo, xhi, ylo, yhi;
  logic [14:0]          dx, dy;

  assign pipe_empty = !(v1_r || v2_r || v3_r || v4_r || v5_r);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign eff_cnt    = q_data.set_start ? '0 : cnt_r;
  assign last_rd    = (CW'(rd_r) + 1'b1) == cnt_r;
  assign keep_now   = !supp_r;
  assign full_now   = keep_now && (cnt_r == CW'(gbs_pkg::MAX_KEPT));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbs_pkg::B_IDLE:  if (qstat.valid) state_nxt = (eff_cnt == '0) ? gbs_pkg::B_DRAIN
                                                                    : gbs_pkg::B_WALK;
      gbs_pkg::B_WALK:  if (last_rd) state_nxt = gbs_pkg::B_DRAIN;
      gbs_pkg::B_DRAIN: if (pipe_empty && out_free) state_nxt = gbs_pkg::B_IDLE;
      default:          state_nxt = gbs_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    fin   = 1'b0;
    unique case (state_r)
      gbs_pkg::B_IDLE:  q_pop = qstat.valid;
      gbs_pkg::B_WALK:  issue = 1'b1;
      gbs_pkg::B_DRAIN: fin   = pipe_empty && out_free;
      default:          ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbs_pkg::B_IDLE;
      cnt_r       <= '0;
      rd_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      supp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      if (q_pop) begin
        rd_r   <= '0;
        supp_r <= 1'b0;
        if (q_data.set_start) cnt_r <= '0;
      end
      if (issue) rd_r <= rd_r + 1'b1;
      if (v5_r && m5_r && ({2'b00, in5_r, 8'd0} > pr5_r)) supp_r <= 1'b1;
      if (fin && keep_now && !full_now) cnt_r <= cnt_r + 1'b1;
      if (fin)               out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload: current item and result
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (fin) begin
      out_keep_r  <= keep_now;
      out_full_r  <= full_now;
      out_index_r <= cur_r.index;
    end
  end

  // kept table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (fin && keep_now && !full_now) begin
      mem_r[cnt_r[AW-1:0]] <= '{left: cur_r.left, top: cur_r.top, width: cur_r.width,
                                height: cur_r.height, area: cur_r.area,
                                label: cur_r.label};
    end
    if (issue) rdata_r <= mem_r[rd_r];
  end

  // overlap along each axis
  always_comb begin
    a0  = 17'(cur_r.left);
    a1  = a0 + $signed({2'b00, cur_r.width});
    b0  = 17'(rdata_r.left);
    b1  = b0 + $signed({2'b00, rdata_r.width});
    c0  = 17'(cur_r.top);
    c1  = c0 + $signed({2'b00, cur_r.height});
    d0  = 17'(rdata_r.top);
    d1  = d0 + $signed({2'b00, rdata_r.height});
    xlo = (a0 > b0) ? a0 : b0;
    xhi = (a1 < b1) ? a1 : b1;
    ylo = (c0 > d0) ? c0 : d0;
    yhi = (c1 < d1) ? c1 : d1;
    dx  = (xhi > xlo) ? 15'(xhi - xlo) : 15'd0;
    dy  = (yhi > ylo) ? 15'(yhi - ylo) : 15'd0;
  end

  // overlap pipeline: widths, intersection, union, scaled union
  always_ff @(posedge clk) begin
    dx2_r <= dx;
    dy2_r <= dy;
    ka2_r <= rdata_r.area;
    m2_r  <= cfg.agnostic || (rdata_r.label == cur_r.label);
    in3_r <= 30'(dx2_r) * 30'(dy2_r);
    ka3_r <= ka2_r;
    m3_r  <= m2_r;
    un4_r <= {1'b0, cur_r.area} + {1'b0, ka3_r} - {1'b0, in3_r};
    in4_r <= in3_r;
    m4_r  <= m3_r;
    pr5_r <= 40'(cfg.thr) * 40'(un4_r);
    in5_r <= in4_r;
    m5_r  <= m4_r;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.keep       = out_keep_r;
  assign out_ch.box_index  = out_index_r;
  assign out_ch.table_full = out_full_r;
endmodule
`default_nettype wire

### src/greedy_box_suppression_top.sv
// greedy box suppression: the back end walks all N stored boxes, one a cycle (N up to 64)
// in the back end an item goes from idle to walk to drain, skipping the walk when N is 0
// throughput is set by the table walk, five stage overlap pipeline drain and result stalls
// an accepted item passes the queue, the back end walk and drain, then the result register
// synchronous active-low reset clears control state; kept table is empty after reset
// configuration reset: threshold 115, class agnostic off
`default_nettype none
module greedy_box_suppression_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  gbs_in_if.sink                            in_ch,
  gbs_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [gbs_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [gbs_pkg::CFG_DW-1:0]   cfg_wdata
);
  gbs_pkg::cfg_t   cfg_r;
  gbs_pkg::qstat_t qstat;
  gbs_pkg::box_t   push_data, q_data;
  logic            push, q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr      <= gbs_pkg::THR_RESET;
      cfg_r.agnostic <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        gbs_pkg::CFG_THR: cfg_r.thr      <= cfg_wdata;
        gbs_pkg::CFG_AGN: cfg_r.agnostic <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  gbs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .qstat(qstat),
    .push(push), .push_data(push_data)
  );

  gbs_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(q_pop), .pop_data(q_data), .stat(qstat)
  );

  gbs_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .qstat(qstat), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

### src/gbs_checker.sv
// port checker for greedy box suppression, bound to the top level
// depends on greedy_box_suppression_top_assert.svh
`default_nettype none
`include "greedy_box_suppression_top_assert.svh"
module gbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_keep,
  input wire logic [15:0] out_box_index,
  input wire logic        out_table_full
);
  logic [17:0] out_word;

  assign out_word = {out_keep, out_box_index, out_table_full};

  // a stalled result holds
  `GBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  // only a kept box can report a full table
  `GBS_ASSERT_NOW(a_full_kept, out_valid && out_table_full, out_keep)
  // no result straight after reset
  `GBS_ASSERT_ALWAYS(a_rst_quiet, !rst_n, !out_valid)
endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_keep(out_ch.keep), .out_box_index(out_ch.box_index),
  .out_table_full(out_ch.table_full)
);
`default_nettype wire

### test/gbs_checker.sv
// checker for greedy box suppression: watches both channels, predicts results
// depends on gbs_pkg
`default_nettype none
module gbs_tb_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_set_start,
  input  wire logic [15:0] in_left,
  input  wire logic [15:0] in_top,
  input  wire logic [14:0] in_width,
  input  wire logic [14:0] in_height,
  input  wire logic [7:0]  in_label,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_keep,
  input  wire logic [15:0] out_index,
  input  wire logic        out_full,
  input  wire logic        cfg_we,
  input  wire logic [gbs_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [gbs_pkg::CFG_DW-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        keep;
    logic [15:0] index;
    logic        full;
  } verdict_t;

  gbs_pkg::kept_t kept_tab [gbs_pkg::MAX_KEPT];
  int             kept_n;
  logic [15:0]    set_pos;
  logic [8:0]     thr;
  logic           agnostic;
  verdict_t       verdicts [$];

  // one-dimensional overlap of [a0,a1) and [b0,b1)
  function automatic longint span_overlap(longint a0, longint a1, longint b0, longint b1);
    longint lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // greedy suppression of one box against the kept table
  function automatic verdict_t suppress_box(logic ss, logic signed [15:0] l,
      logic signed [15:0] t, logic [14:0] w, logic [14:0] h, logic [7:0] lab);
    verdict_t v;
    longint ll, tt, ww, hh, ar, kl, kt, inter, uni;
    ll = l; tt = t; ww = w; hh = h;
    ar = ww * hh;
    if (ss) begin
      kept_n = 0;
      set_pos = 0;
    end
    v.index = set_pos;
    if (set_pos != 16'hFFFF) set_pos++;
    v.keep = 1'b1;
    v.full = 1'b0;
    for (int i = 0; i < kept_n; i++) begin
      if (!agnostic && kept_tab[i].label != lab) continue;
      kl = kept_tab[i].left;
      kt = kept_tab[i].top;
      inter = span_overlap(ll, ll + ww, kl, kl + kept_tab[i].width) *
              span_overlap(tt, tt + hh, kt, kt + kept_tab[i].height);
      uni = ar + longint'(kept_tab[i].area) - inter;
      if (inter * 256 > longint'(thr) * uni) v.keep = 1'b0;
    end
    if (v.keep) begin
      if (kept_n < gbs_pkg::MAX_KEPT) begin
        kept_tab[kept_n] = '{left: l, top: t, width: w, height: h,
                             area: ar[29:0], label: lab};
        kept_n++;
      end else begin
        v.full = 1'b1;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      kept_n     = 0;
      set_pos    = 0;
      thr        = gbs_pkg::THR_RESET;
      agnostic   = 1'b0;
      fail_count = 0;
      verdicts.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == gbs_pkg::CFG_THR) thr = cfg_wdata;
        else if (cfg_index == gbs_pkg::CFG_AGN) agnostic = cfg_wdata[0];
      end
      // accepted box
      if (in_valid && in_ready)
        verdicts = {verdicts, suppress_box(in_set_start, in_left, in_top,
                                           in_width, in_height, in_label)};
      // accepted result
      if (out_valid && out_ready) begin
        if (verdicts.size() == 0) begin
          $error("unexpected result item");
          fail_count++;
        end else begin
          exp_v = verdicts.pop_front();
          if (out_keep !== exp_v.keep) begin
            $error("keep: expected %0d actual %0d", exp_v.keep, out_keep);
            fail_count++;
          end
          if (out_index !== exp_v.index) begin
            $error("box_index: expected %0d actual %0d", exp_v.index, out_index);
            fail_count++;
          end
          if (out_full !== exp_v.full) begin
            $error("table_full: expected %0d actual %0d", exp_v.full, out_full);
            fail_count++;
          end
        end
      end
    end
    pending = verdicts.size();
  end
endmodule
`default_nettype wire

### test/tb_top.sv
// top of the greedy box suppression testbench: stimulus, idling and verdict
// depends on gbs_pkg, gbs_if, gbs_tb_checker and the block itself
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gbs_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [gbs_pkg::CFG_DW-1:0] cfg_wdata = '0;
  int fail_count, pending;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  gbs_in_if  in_ch ();
  gbs_out_if out_ch ();

  greedy_box_suppression_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  gbs_tb_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_set_start(in_ch.set_start),
    .in_left(in_ch.box_left), .in_top(in_ch.box_top), .in_width(in_ch.box_width),
    .in_height(in_ch.box_height), .in_label(in_ch.class_label),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_keep(out_ch.keep),
    .out_index(out_ch.box_index), .out_full(out_ch.table_full),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("greedy_box_suppression_top: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_reg(logic [gbs_pkg::CFG_IW-1:0] idx,
                           logic [gbs_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one box and wait until it is accepted; valid stays up for the next item
  task automatic send_box(logic ss, logic [15:0] l, logic [15:0] t,
                          logic [14:0] w, logic [14:0] h, logic [7:0] lab);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.set_start <= ss;
    in_ch.box_left <= l;
    in_ch.box_top <= t;
    in_ch.box_width <= w;
    in_ch.box_height <= h;
    in_ch.class_label <= lab;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering, wait until every result is back, then run on with the input idle
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // random box, mostly clustered so that overlaps are common
  task automatic random_box(bit ss);
    logic [15:0] l, t;
    logic [14:0] w, h;
    logic [7:0] lab;
    if ($urandom_range(9) == 0) begin
      l = 16'($urandom); t = 16'($urandom); w = 15'($urandom); h = 15'($urandom);
      lab = 8'($urandom);
    end else begin
      l = 16'($signed($urandom_range(1200)) - 600);
      t = 16'($signed($urandom_range(1200)) - 600);
      w = 15'($urandom_range(400));
      h = 15'($urandom_range(400));
      lab = 8'($urandom_range(2));
    end
    send_box(ss, l, t, w, h, lab);
  endtask

  task automatic random_phase(int n, int si, int rs);
    send_idle = si;
    recv_stall = rs;
    for (int i = 0; i < n; i++)
      random_box(i == 0 || $urandom_range(39) == 0);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.set_start = 1'b0;
    in_ch.box_left = '0;
    in_ch.box_top = '0;
    in_ch.box_width = '0;
    in_ch.box_height = '0;
    in_ch.class_label = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, overlaps, zero area, labels
    send_box(1'b1, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 8'hFF);
    send_box(1'b0, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 8'hFF);
    send_box(1'b0, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 8'hFF);
    send_box(1'b0, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 8'h00);
    send_box(1'b1, 16'd0, 16'd0, 15'd0, 15'd0, 8'd0);
    send_box(1'b0, 16'd0, 16'd0, 15'd0, 15'd0, 8'd0);
    send_box(1'b0, 16'd0, 16'd0, 15'd100, 15'd100, 8'd0);
    send_box(1'b0, 16'd100, 16'd0, 15'd100, 15'd100, 8'd0);
    send_box(1'b0, 16'd10, 16'd10, 15'd100, 15'd100, 8'd0);
    send_box(1'b0, 16'd50, 16'd0, 15'd100, 15'd100, 8'd0);
    drain();
    write_reg(gbs_pkg::CFG_THR, 9'd0);
    send_box(1'b1, 16'd0, 16'd0, 15'd100, 15'd100, 8'd1);
    send_box(1'b0, 16'd99, 16'd99, 15'd100, 15'd100, 8'd1);
    send_box(1'b0, 16'd100, 16'd100, 15'd10, 15'd10, 8'd1);
    drain();
    write_reg(gbs_pkg::CFG_THR, 9'd256);
    write_reg(gbs_pkg::CFG_AGN, 9'd1);
    send_box(1'b1, 16'd0, 16'd0, 15'd100, 15'd100, 8'd1);
    send_box(1'b0, 16'd0, 16'd0, 15'd100, 15'd100, 8'd2);
    drain();
    write_reg(gbs_pkg::CFG_THR, 9'd511);
    send_box(1'b0, 16'd0, 16'd0, 15'd100, 15'd100, 8'd3);
    // table fill then overflow with disjoint boxes
    for (int i = 0; i < 70; i++)
      send_box(i == 0, 16'(i * 64), 16'd0, 15'd32, 15'd32, 8'(i));
    drain();

    // long hold-off on the receiver while boxes keep coming
    write_reg(gbs_pkg::CFG_THR, 9'd115);
    write_reg(gbs_pkg::CFG_AGN, 9'd0);
    hold_off <= 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < 10; i++) random_box(i == 0);
    drain();

    // random phases over several settings
    random_phase(250, 0, 0);
    write_reg(gbs_pkg::CFG_THR, 9'd0);
    write_reg(gbs_pkg::CFG_AGN, 9'd1);
    random_phase(150, 76, 0);
    write_reg(gbs_pkg::CFG_THR, 9'd256);
    random_phase(100, 0, 76);
    write_reg(gbs_pkg::CFG_THR, 9'($urandom_range(255)));
    write_reg(gbs_pkg::CFG_AGN, 9'd0);
    random_phase(200, 30, 30);
    write_reg(gbs_pkg::CFG_THR, 9'd115);
    random_phase(150, 0, 0);
    write_reg(gbs_pkg::CFG_THR, 9'd511);
    write_reg(gbs_pkg::CFG_AGN, 9'd1);
    random_phase(50, 30, 30);

    if (fail_count == 0) begin
      $display("greedy_box_suppression_top: match");
    end else begin
      $display("greedy_box_suppression_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
